// ===== rtl/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg: shared types and constants for the binary heap priority queue
// Sizes, status codes, the entry layout and the microcode action fields.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int ID_BITS  = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  id;
  } entry_t;

  // microcode step addresses
  typedef enum logic [3:0] {
    U_IDLE, U_DISP, U_PUSH0, U_UP_RD, U_UP_CMP, U_UP_WR, U_FULL,
    U_POP0, U_POP1, U_DN_RD, U_DN_CMP, U_DN_WR, U_EMPTY, U_FINISH
  } step_t;

  // datapath action fields; the first member of each is the idle choice
  typedef enum logic [1:0] {RA_ROOT, RA_PARENT, RA_LEFT}          ra_sel_t;
  typedef enum logic       {RB_LAST, RB_RIGHT}                    rb_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_HOLD, WR_RDA, WR_PICK}    wr_sel_t;
  typedef enum logic [2:0] {
    IDX_KEEP, IDX_COUNT, IDX_ZERO, IDX_PARENT, IDX_PICK
  } idx_sel_t;
  typedef enum logic [1:0] {CNT_KEEP, CNT_INC, CNT_DEC}           cnt_op_t;
  typedef enum logic [1:0] {RES_KEEP, RES_CLEAR, RES_ROOT}        res_sel_t;
  typedef enum logic [1:0] {SS_KEEP, SS_OK, SS_EMPTY, SS_FULL}    st_sel_t;

  typedef struct packed {
    ra_sel_t  ra_sel;
    rb_sel_t  rb_sel;
    wr_sel_t  wr_sel;
    idx_sel_t idx_sel;
    cnt_op_t  cnt_op;
    logic     hold_ld;
    res_sel_t res_sel;
    st_sel_t  st_sel;
    logic     done;
  } act_t;

  // status flags from the datapath, tested by the sequencer
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic idx_zero;
    logic no_up;
    logic no_left;
    logic no_down;
  } dp_flags_t;

  // true when key a belongs above key b
  function automatic logic ahead(input logic mode,
                                 input logic [KEY_BITS-1:0] a,
                                 input logic [KEY_BITS-1:0] b);
    return mode ? (a > b) : (a < b);
  endfunction

endpackage

// ===== rtl/binary_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue: array binary heap with push and pop
// Top level: handshakes, order register, output register, sequencer and
// datapath.
// ----------------------------------------------------------------------------
// Holds up to CAPACITY entries (a key and an id) in a binary heap kept in a
// single slot memory with one write and two registered read ports. cfg_wr_data
// picks the order: 0 puts the smallest key at the root, 1 the largest; the
// stored layout is not reordered when it changes, so write it while idle.
// One item is worked at a time by a microcoded sequencer. Each heap level
// takes a read step (the parent or both children) and then a compare and
// move step. A push ends when the entry stops rising or reaches the root,
// a pop when the last entry stops sinking or reaches a leaf; pop on empty
// and push on full set their status and go to the finish step. The finish
// step waits while the previous result is still stalled.
// Every transfer in gives exactly one transfer out; a finished result waits in
// an output register, so the next item is taken while the result is stalled.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic [bhpq_pkg::KEY_BITS-1:0]       in_entry_key,
  input  logic [bhpq_pkg::ID_BITS-1:0]        in_entry_id,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [bhpq_pkg::ID_BITS-1:0]        out_popped_id,
  output logic [bhpq_pkg::KEY_BITS-1:0]       out_popped_key,
  output logic [bhpq_pkg::CNT_W-1:0]          out_fill_count,
  // order register
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data
);

  logic                              mode_r;
  logic                              idle, in_take, out_busy;
  bhpq_pkg::act_t                    act;
  bhpq_pkg::dp_flags_t               flags;
  logic [1:0]                        res_status;
  logic [bhpq_pkg::KEY_BITS-1:0]     res_key;
  logic [bhpq_pkg::ID_BITS-1:0]      res_id;
  logic [bhpq_pkg::CNT_W-1:0]        fill;

  logic                              out_valid_r, out_valid_nxt;
  logic [1:0]                        out_status_r;
  logic [bhpq_pkg::KEY_BITS-1:0]     out_key_r;
  logic [bhpq_pkg::ID_BITS-1:0]      out_id_r;
  logic [bhpq_pkg::CNT_W-1:0]        out_fill_r;

  // an input transfer only happens while the sequencer sits in its idle step
  assign in_stall = !idle;
  assign in_take  = in_valid && idle;
  // the output register cannot take a new result this cycle
  assign out_busy = out_valid_r && out_stall;

  bhpq_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_take),
    .out_busy (out_busy),
    .flags    (flags),
    .idle     (idle),
    .act      (act)
  );

  bhpq_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .mode         (mode_r),
    .in_take      (in_take),
    .in_operation (in_operation),
    .in_key       (in_entry_key),
    .in_id        (in_entry_id),
    .act          (act),
    .flags        (flags),
    .res_status   (res_status),
    .res_key      (res_key),
    .res_id       (res_id),
    .fill         (fill)
  );

  // output register: loaded by the finish step, cleared by a transfer out
  always_comb begin
    if (act.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (act.done) begin
      out_status_r <= res_status;
      out_key_r    <= res_key;
      out_id_r     <= res_id;
      out_fill_r   <= fill;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_popped_key = out_key_r;
  assign out_popped_id  = out_id_r;
  assign out_fill_count = out_fill_r;

`ifndef NO_ASSERTIONS
  // a taken item keeps the block busy on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("input not stalled after a transfer in");

  // the finish step never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    act.done |-> !out_busy)
    else $error("result loaded while output register stalled");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill_count <= bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY)))
    else $error("fill count beyond capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bhpq_pkg::ST_FULL)
      |-> (out_fill_count == bhpq_pkg::CNT_W'(bhpq_pkg::CAPACITY)))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bhpq_pkg::ST_EMPTY)
      |-> (out_fill_count == '0 && out_popped_key == '0 && out_popped_id == '0))
    else $error("empty status with entries or nonzero result");
`endif

endmodule

// ===== rtl/bhpq_useq.sv =====
// ----------------------------------------------------------------------------
// bhpq_useq: microcode sequencer
// Step counter, control store and two-way conditional branch per step.
// ----------------------------------------------------------------------------
module bhpq_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                out_busy,
  input  bhpq_pkg::dp_flags_t flags,
  output logic                idle,
  output bhpq_pkg::act_t      act
);

  typedef enum logic [3:0] {
    C_ALWAYS, C_START, C_IS_POP, C_FULL, C_EMPTY, C_IDX_ZERO,
    C_NO_UP, C_NO_LEFT, C_NO_DOWN, C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    cond_t           cond;
    bhpq_pkg::step_t jmp_to;
    bhpq_pkg::step_t fall_to;
    logic            guard;   // suppress actions when the branch is taken
    bhpq_pkg::act_t  act;
  } uword_t;

  bhpq_pkg::step_t upc_r, upc_nxt;
  uword_t          uw;
  logic            taken;

  // control store
  always_comb begin
    uw = '0;
    case (upc_r)
      bhpq_pkg::U_IDLE: begin
        uw.cond = C_START;    uw.jmp_to = bhpq_pkg::U_DISP;
        uw.fall_to = bhpq_pkg::U_IDLE;
      end
      bhpq_pkg::U_DISP: begin
        uw.cond = C_IS_POP;   uw.jmp_to = bhpq_pkg::U_POP0;
        uw.fall_to = bhpq_pkg::U_PUSH0;
        uw.act.res_sel = bhpq_pkg::RES_CLEAR;
        uw.act.st_sel  = bhpq_pkg::SS_OK;
      end
      bhpq_pkg::U_PUSH0: begin
        uw.cond = C_FULL;     uw.jmp_to = bhpq_pkg::U_FULL;
        uw.fall_to = bhpq_pkg::U_UP_RD;
        uw.guard = 1'b1;
        uw.act.idx_sel = bhpq_pkg::IDX_COUNT;
      end
      bhpq_pkg::U_UP_RD: begin
        uw.cond = C_IDX_ZERO; uw.jmp_to = bhpq_pkg::U_UP_WR;
        uw.fall_to = bhpq_pkg::U_UP_CMP;
        uw.act.ra_sel = bhpq_pkg::RA_PARENT;
      end
      bhpq_pkg::U_UP_CMP: begin
        uw.cond = C_NO_UP;    uw.jmp_to = bhpq_pkg::U_UP_WR;
        uw.fall_to = bhpq_pkg::U_UP_RD;
        uw.guard = 1'b1;
        uw.act.wr_sel  = bhpq_pkg::WR_RDA;
        uw.act.idx_sel = bhpq_pkg::IDX_PARENT;
      end
      bhpq_pkg::U_UP_WR: begin
        uw.cond = C_ALWAYS;   uw.jmp_to = bhpq_pkg::U_FINISH;
        uw.fall_to = bhpq_pkg::U_FINISH;
        uw.act.wr_sel = bhpq_pkg::WR_HOLD;
        uw.act.cnt_op = bhpq_pkg::CNT_INC;
      end
      bhpq_pkg::U_FULL: begin
        uw.cond = C_ALWAYS;   uw.jmp_to = bhpq_pkg::U_FINISH;
        uw.fall_to = bhpq_pkg::U_FINISH;
        uw.act.st_sel = bhpq_pkg::SS_FULL;
      end
      bhpq_pkg::U_POP0: begin
        uw.cond = C_EMPTY;    uw.jmp_to = bhpq_pkg::U_EMPTY;
        uw.fall_to = bhpq_pkg::U_POP1;
        uw.guard = 1'b1;
        uw.act.ra_sel = bhpq_pkg::RA_ROOT;
        uw.act.rb_sel = bhpq_pkg::RB_LAST;
        uw.act.cnt_op = bhpq_pkg::CNT_DEC;
      end
      bhpq_pkg::U_POP1: begin
        uw.cond = C_ALWAYS;   uw.jmp_to = bhpq_pkg::U_DN_RD;
        uw.fall_to = bhpq_pkg::U_DN_RD;
        uw.act.res_sel = bhpq_pkg::RES_ROOT;
        uw.act.hold_ld = 1'b1;
        uw.act.idx_sel = bhpq_pkg::IDX_ZERO;
      end
      bhpq_pkg::U_DN_RD: begin
        uw.cond = C_NO_LEFT;  uw.jmp_to = bhpq_pkg::U_DN_WR;
        uw.fall_to = bhpq_pkg::U_DN_CMP;
        uw.act.ra_sel = bhpq_pkg::RA_LEFT;
        uw.act.rb_sel = bhpq_pkg::RB_RIGHT;
      end
      bhpq_pkg::U_DN_CMP: begin
        uw.cond = C_NO_DOWN;  uw.jmp_to = bhpq_pkg::U_DN_WR;
        uw.fall_to = bhpq_pkg::U_DN_RD;
        uw.guard = 1'b1;
        uw.act.wr_sel  = bhpq_pkg::WR_PICK;
        uw.act.idx_sel = bhpq_pkg::IDX_PICK;
      end
      bhpq_pkg::U_DN_WR: begin
        uw.cond = C_ALWAYS;   uw.jmp_to = bhpq_pkg::U_FINISH;
        uw.fall_to = bhpq_pkg::U_FINISH;
        uw.act.wr_sel = bhpq_pkg::WR_HOLD;
      end
      bhpq_pkg::U_EMPTY: begin
        uw.cond = C_ALWAYS;   uw.jmp_to = bhpq_pkg::U_FINISH;
        uw.fall_to = bhpq_pkg::U_FINISH;
        uw.act.st_sel = bhpq_pkg::SS_EMPTY;
      end
      bhpq_pkg::U_FINISH: begin
        uw.cond = C_OUT_BUSY; uw.jmp_to = bhpq_pkg::U_FINISH;
        uw.fall_to = bhpq_pkg::U_IDLE;
        uw.guard = 1'b1;
        uw.act.done = 1'b1;
      end
      default: begin
        uw.cond = C_ALWAYS;   uw.jmp_to = bhpq_pkg::U_IDLE;
        uw.fall_to = bhpq_pkg::U_IDLE;
      end
    endcase
  end

  // branch condition
  always_comb begin
    case (uw.cond)
      C_ALWAYS:   taken = 1'b1;
      C_START:    taken = start;
      C_IS_POP:   taken = flags.is_pop;
      C_FULL:     taken = flags.full;
      C_EMPTY:    taken = flags.empty;
      C_IDX_ZERO: taken = flags.idx_zero;
      C_NO_UP:    taken = flags.no_up;
      C_NO_LEFT:  taken = flags.no_left;
      C_NO_DOWN:  taken = flags.no_down;
      C_OUT_BUSY: taken = out_busy;
      default:    taken = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    upc_nxt = taken ? uw.jmp_to : uw.fall_to;
  end

  // outputs
  always_comb begin
    act  = (uw.guard && taken) ? '0 : uw.act;
    idle = (upc_r == bhpq_pkg::U_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= bhpq_pkg::U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== rtl/bhpq_dpath.sv =====
// ----------------------------------------------------------------------------
// bhpq_dpath: heap datapath
// Slot memory with two registered read ports, index and count registers,
// key compare and the result registers.
// ----------------------------------------------------------------------------
module bhpq_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              mode,
  input  logic                              in_take,
  input  logic                              in_operation,
  input  logic [bhpq_pkg::KEY_BITS-1:0]     in_key,
  input  logic [bhpq_pkg::ID_BITS-1:0]      in_id,
  input  bhpq_pkg::act_t                    act,
  output bhpq_pkg::dp_flags_t               flags,
  output logic [1:0]                        res_status,
  output logic [bhpq_pkg::KEY_BITS-1:0]     res_key,
  output logic [bhpq_pkg::ID_BITS-1:0]      res_id,
  output logic [bhpq_pkg::CNT_W-1:0]        fill
);

  localparam int AW = bhpq_pkg::ADDR_W;
  localparam int NW = bhpq_pkg::CNT_W;
  localparam int CW = AW + 2;

  bhpq_pkg::entry_t  mem_r [bhpq_pkg::CAPACITY];
  bhpq_pkg::entry_t  rda_r, rdb_r;
  bhpq_pkg::entry_t  hold_r, hold_nxt;
  bhpq_pkg::entry_t  res_r, res_nxt;
  bhpq_pkg::entry_t  wd, pick;
  bhpq_pkg::status_t stat_r, stat_nxt;
  logic              op_r;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt, cnt_m1;
  logic [AW-1:0]     ra, rb, parent, pick_addr;
  logic [CW-1:0]     left_w, right_w, cnt_ext;
  logic              pick_right, we;

  // heap index arithmetic
  always_comb begin
    parent     = (idx_r - AW'(1)) >> 1;
    left_w     = {1'b0, idx_r, 1'b1};
    right_w    = left_w + CW'(1);
    cnt_ext    = {{(CW-NW){1'b0}}, cnt_r};
    cnt_m1     = cnt_r - NW'(1);
    pick_right = (right_w < cnt_ext) && bhpq_pkg::ahead(mode, rdb_r.key, rda_r.key);
    pick       = pick_right ? rdb_r : rda_r;
    pick_addr  = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
  end

  always_comb begin
    flags.is_pop   = (op_r == bhpq_pkg::OP_POP);
    flags.full     = (cnt_r == NW'(bhpq_pkg::CAPACITY));
    flags.empty    = (cnt_r == '0);
    flags.idx_zero = (idx_r == '0);
    flags.no_up    = !bhpq_pkg::ahead(mode, hold_r.key, rda_r.key);
    flags.no_left  = (left_w >= cnt_ext);
    flags.no_down  = !bhpq_pkg::ahead(mode, pick.key, hold_r.key);
  end

  // read addresses
  always_comb begin
    case (act.ra_sel)
      bhpq_pkg::RA_ROOT:   ra = '0;
      bhpq_pkg::RA_PARENT: ra = parent;
      bhpq_pkg::RA_LEFT:   ra = left_w[AW-1:0];
      default:             ra = '0;
    endcase
    case (act.rb_sel)
      bhpq_pkg::RB_LAST:  rb = cnt_m1[AW-1:0];
      bhpq_pkg::RB_RIGHT: rb = right_w[AW-1:0];
      default:            rb = '0;
    endcase
  end

  // write port, always at the current index
  always_comb begin
    case (act.wr_sel)
      bhpq_pkg::WR_HOLD: begin we = 1'b1; wd = hold_r; end
      bhpq_pkg::WR_RDA:  begin we = 1'b1; wd = rda_r;  end
      bhpq_pkg::WR_PICK: begin we = 1'b1; wd = pick;   end
      default:           begin we = 1'b0; wd = hold_r; end
    endcase
  end

  always_comb begin
    case (act.idx_sel)
      bhpq_pkg::IDX_COUNT:  idx_nxt = cnt_r[AW-1:0];
      bhpq_pkg::IDX_ZERO:   idx_nxt = '0;
      bhpq_pkg::IDX_PARENT: idx_nxt = parent;
      bhpq_pkg::IDX_PICK:   idx_nxt = pick_addr;
      default:              idx_nxt = idx_r;
    endcase
    case (act.cnt_op)
      bhpq_pkg::CNT_INC: cnt_nxt = cnt_r + NW'(1);
      bhpq_pkg::CNT_DEC: cnt_nxt = cnt_m1;
      default:           cnt_nxt = cnt_r;
    endcase
    case (act.res_sel)
      bhpq_pkg::RES_CLEAR: res_nxt = '0;
      bhpq_pkg::RES_ROOT:  res_nxt = rda_r;
      default:             res_nxt = res_r;
    endcase
    case (act.st_sel)
      bhpq_pkg::SS_OK:    stat_nxt = bhpq_pkg::ST_OK;
      bhpq_pkg::SS_EMPTY: stat_nxt = bhpq_pkg::ST_EMPTY;
      bhpq_pkg::SS_FULL:  stat_nxt = bhpq_pkg::ST_FULL;
      default:            stat_nxt = stat_r;
    endcase
    if (in_take) begin
      hold_nxt.key = in_key;
      hold_nxt.id  = in_id;
    end else if (act.hold_ld) begin
      hold_nxt = rdb_r;
    end else begin
      hold_nxt = hold_r;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[idx_r] <= wd;
    end
    rda_r <= mem_r[ra];
    rdb_r <= mem_r[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r <= in_operation;
    end
    idx_r  <= idx_nxt;
    hold_r <= hold_nxt;
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
  end

  assign res_status = stat_r;
  assign res_key    = res_r.key;
  assign res_id     = res_r.id;
  assign fill       = cnt_r;

endmodule
